// ----- rtl/core/bfa_pkg.sv -----
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

  localparam int ADDR_W  = 64;
  localparam int COUNT_W = 13;
  localparam int CMD_W   = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIXED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RANGE = 3'd4;

  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] count;
  } request_t;

  typedef struct packed {
    logic               ok;
    logic [ADDR_W-1:0]  result_address;
    logic [COUNT_W-1:0] free_frames;
  } result_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_OFF,
    S_SPAN,
    S_FIT,
    S_FREE_RD,
    S_FREE_WR,
    S_SCAN,
    S_MARK,
    S_CLEAR,
    S_ADDR,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/bfa_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bitmap_frame_allocator_top.sv -----
// Bitmap frame allocator: used/free map in a word RAM plus a free-frame counter.
//
// Usage: drive request and pulse start while busy is low; the item is taken at
// that edge. Exactly one result follows, shown on result for one cycle with
// done high; the receiver cannot stall it. Configuration (base address, frame
// count) is written through cfg_we/cfg_index/cfg_data while the block is idle.
//
// The map is kept as 64-bit words, WORDS = ceil(MAX_FRAMES/64), in one RAM with
// one read and one write port. Searches stream one word per cycle through the
// read port and write modified words back behind the read.
//   clear        : sweep of zero words over the whole map
//   free         : read the word, clear the bit, write the word back
//   alloc single : a search over up to nw words, nw = ceil(n/64)
//   alloc fixed  : two passes over the covered words (check, then mark)
//   alloc range  : a search over up to nw words, plus the marking pass
// With 4096 frames a search pass is at most 64 word reads.
// Reset starts a sweep over all WORDS words (64 by default) that clears the map;
// busy stays high until it ends. Config writes are taken during it.
module bitmap_frame_allocator_top #(
  parameter int MAX_FRAMES       = 4096,
  parameter int FRAME_BYTES_LOG2 = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bfa_pkg::request_t request,
  output logic              done,
  output bfa_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data
);

  localparam int WORDS  = (MAX_FRAMES + 63) / 64;
  localparam int WA     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int XW     = (WA + 7 > 14) ? WA + 7 : 14;
  localparam int LOG2   = FRAME_BYTES_LOG2;
  localparam logic [XW-1:0] MAXV = XW'(MAX_FRAMES);
  localparam logic [WA-1:0] LAST_WORD = WA'(WORDS - 1);

  bfa_pkg::state_t state, state_next;

  logic [63:0]   base;
  logic [12:0]   frames;
  logic [2:0]    cmd_q;
  logic [63:0]   addr_q;
  logic [XW-1:0] cnt_q;
  logic [XW-1:0] free_cnt;
  logic [63:0]   off_q;
  logic          ge_q;
  logic [63:0]   diff_q;
  logic [XW-1:0] lo_q;
  logic [XW-1:0] hi_q;
  logic [XW-1:0] start_q;
  logic [XW-1:0] run_q;
  logic [WA-1:0] rd_ptr;
  logic [WA-1:0] rd_end;
  logic          rd_more;
  logic          rd_vld;
  logic [WA-1:0] rd_word;
  logic          res_ok;
  logic [63:0]   res_addr;

  logic          ram_we;
  logic [WA-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [WA-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  // derived values
  logic [XW-1:0] n;
  logic [WA-1:0] nw_last;
  logic [63:0]   span;
  logic [XW-1:0] req_cnt;
  logic [63:0]   idx64;
  logic [XW-1:0] lo_calc;
  logic [XW-1:0] hi_calc;
  logic [64:0]   span_sub;

  assign n       = (XW'(frames) > MAXV) ? MAXV : XW'(frames);
  assign nw_last = WA'((n + XW'(63)) >> 6) - WA'(1);
  assign span    = 64'(n) << LOG2;
  assign req_cnt = XW'(request.count);
  assign idx64   = off_q >> LOG2;
  assign lo_calc = XW'(idx64);
  assign hi_calc = lo_calc + cnt_q;
  assign span_sub = {1'b0, span} - {1'b0, off_q};

  // per-word evaluation of the arriving map word
  logic [63:0]   valid_mask;
  logic [63:0]   range_mask;
  logic [63:0]   avail;
  logic          any_free;
  logic [5:0]    free_j;
  logic          any_hit;
  logic [5:0]    hit_j;
  logic [XW-1:0] run_v [64];
  logic          rd_last;

  always_comb begin
    logic [XW-1:0] g;
    logic          seen;
    logic [5:0]    p;
    valid_mask = '0;
    range_mask = '0;
    for (int j = 0; j < 64; j++) begin
      g = XW'({rd_word, 6'(j)});
      valid_mask[j] = (g < n);
      range_mask[j] = (g >= lo_q) && (g < hi_q);
    end
    avail = ~ram_rdata & valid_mask;
    any_free = |avail;
    free_j = '0;
    for (int j = 63; j >= 0; j--) begin
      if (avail[j]) begin
        free_j = 6'(j);
      end
    end
    // length of the free run that ends at each bit, carried across words
    for (int j = 0; j < 64; j++) begin
      seen = 1'b0;
      p = '0;
      for (int k = 0; k <= j; k++) begin
        if (!avail[k]) begin
          seen = 1'b1;
          p = 6'(k);
        end
      end
      run_v[j] = seen ? XW'(6'(j) - p) : run_q + XW'(j + 1);
    end
    any_hit = 1'b0;
    hit_j = '0;
    for (int j = 63; j >= 0; j--) begin
      if (run_v[j] >= cnt_q) begin
        any_hit = 1'b1;
        hit_j = 6'(j);
      end
    end
  end

  assign rd_last = (rd_word == rd_end);

  logic [XW-1:0] hit_start;
  logic [XW-1:0] free_g;
  logic [XW-1:0] dec_cnt;
  assign hit_start = XW'({rd_word, hit_j}) + XW'(1) - cnt_q;
  assign free_g    = XW'({rd_word, free_j});
  assign dec_cnt   = (free_cnt >= cnt_q) ? free_cnt - cnt_q : '0;

  bfa_ram #(
    .WIDTH(64),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfa_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and RAM control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = rd_word;
    ram_wdata  = '0;
    ram_raddr  = rd_ptr;
    unique case (state)
      bfa_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = rd_ptr;
        if (rd_ptr == LAST_WORD) state_next = bfa_pkg::S_IDLE;
      end
      bfa_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_ptr;
        if (rd_ptr == LAST_WORD) state_next = bfa_pkg::S_DONE;
      end
      bfa_pkg::S_IDLE: begin
        if (start) begin
          case (request.command)
            bfa_pkg::CMD_CLEAR:
              state_next = (frames != '0) ? bfa_pkg::S_CLEAR : bfa_pkg::S_DONE;
            bfa_pkg::CMD_ALLOC:
              state_next = (free_cnt != '0 && n != '0) ? bfa_pkg::S_SCAN
                                                        : bfa_pkg::S_DONE;
            bfa_pkg::CMD_FREE, bfa_pkg::CMD_FIXED:
              state_next = bfa_pkg::S_OFF;
            bfa_pkg::CMD_RANGE:
              state_next = (req_cnt != '0 && req_cnt <= free_cnt && n != '0)
                           ? bfa_pkg::S_SCAN : bfa_pkg::S_DONE;
            default:
              state_next = bfa_pkg::S_DONE;
          endcase
        end
      end
      bfa_pkg::S_OFF: begin
        if (cmd_q == bfa_pkg::CMD_FREE) begin
          state_next = bfa_pkg::S_FIT;
        end else begin
          state_next = (addr_q >= base && cnt_q != '0) ? bfa_pkg::S_SPAN
                                                        : bfa_pkg::S_DONE;
        end
      end
      bfa_pkg::S_SPAN: begin
        state_next = span_sub[64] ? bfa_pkg::S_DONE : bfa_pkg::S_FIT;
      end
      bfa_pkg::S_FIT: begin
        if (cmd_q == bfa_pkg::CMD_FREE) begin
          state_next = (ge_q && idx64 < 64'(n)) ? bfa_pkg::S_FREE_RD : bfa_pkg::S_DONE;
        end else begin
          state_next = ((64'(cnt_q) << LOG2) <= diff_q) ? bfa_pkg::S_SCAN
                                                         : bfa_pkg::S_DONE;
        end
      end
      bfa_pkg::S_FREE_RD: begin
        ram_raddr  = lo_q[WA+5:6];
        state_next = bfa_pkg::S_FREE_WR;
      end
      bfa_pkg::S_FREE_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = lo_q[WA+5:6];
        ram_wdata  = ram_rdata & ~(64'd1 << lo_q[5:0]);
        state_next = bfa_pkg::S_DONE;
      end
      bfa_pkg::S_SCAN: begin
        if (rd_vld) begin
          case (cmd_q)
            bfa_pkg::CMD_ALLOC: begin
              if (any_free) begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata | (64'd1 << free_j);
                state_next = bfa_pkg::S_ADDR;
              end else if (rd_last) begin
                state_next = bfa_pkg::S_DONE;
              end
            end
            bfa_pkg::CMD_RANGE: begin
              if (any_hit) state_next = bfa_pkg::S_MARK;
              else if (rd_last) state_next = bfa_pkg::S_DONE;
            end
            default: begin
              if ((ram_rdata & range_mask) != '0) state_next = bfa_pkg::S_DONE;
              else if (rd_last) state_next = bfa_pkg::S_MARK;
            end
          endcase
        end
      end
      bfa_pkg::S_MARK: begin
        if (rd_vld) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | range_mask;
          if (rd_last) begin
            state_next = (cmd_q == bfa_pkg::CMD_FIXED) ? bfa_pkg::S_DONE
                                                       : bfa_pkg::S_ADDR;
          end
        end
      end
      bfa_pkg::S_ADDR: state_next = bfa_pkg::S_DONE;
      bfa_pkg::S_DONE: state_next = bfa_pkg::S_IDLE;
      default:         state_next = bfa_pkg::S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= '0;
      frames <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bfa_pkg::REG_BASE:   base   <= cfg_data;
        bfa_pkg::REG_FRAMES: frames <= cfg_data[12:0];
        default:             base   <= base;
      endcase
    end
  end

  // read pointer and streaming control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      rd_more <= 1'b0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      if (state == bfa_pkg::S_INIT || state == bfa_pkg::S_CLEAR) begin
        rd_ptr <= rd_ptr + WA'(1);
      end else if (state == bfa_pkg::S_IDLE) begin
        rd_ptr  <= '0;
        rd_end  <= nw_last;
        rd_more <= 1'b1;
      end else if (state == bfa_pkg::S_FIT) begin
        rd_ptr  <= lo_calc[WA+5:6];
        rd_end  <= WA'((hi_calc - XW'(1)) >> 6);
        rd_more <= 1'b1;
      end else if (state_next == bfa_pkg::S_MARK && state == bfa_pkg::S_SCAN) begin
        // restart the stream over the words to be marked
        if (cmd_q == bfa_pkg::CMD_RANGE) begin
          rd_ptr <= hit_start[WA+5:6];
          rd_end <= WA'((hit_start + cnt_q - XW'(1)) >> 6);
        end else begin
          rd_ptr <= lo_q[WA+5:6];
          rd_end <= WA'((hi_q - XW'(1)) >> 6);
        end
        rd_more <= 1'b1;
      end else if (state == bfa_pkg::S_SCAN || state == bfa_pkg::S_MARK) begin
        if (rd_more) begin
          rd_vld  <= 1'b1;
          rd_word <= rd_ptr;
          if (rd_ptr == rd_end) rd_more <= 1'b0;
          else rd_ptr <= rd_ptr + WA'(1);
        end
      end
    end
  end

  // datapath and result
  always_ff @(posedge clk) begin
    if (rst) begin
      free_cnt <= '0;
    end else begin
      case (state)
        bfa_pkg::S_IDLE: begin
          cmd_q    <= request.command;
          addr_q   <= request.address;
          cnt_q    <= req_cnt;
          run_q    <= '0;
          res_ok   <= 1'b0;
          res_addr <= '0;
          lo_q     <= '0;
          hi_q     <= '0;
        end
        bfa_pkg::S_CLEAR: begin
          if (rd_ptr == LAST_WORD) begin
            free_cnt <= n;
            res_ok   <= 1'b1;
          end
        end
        bfa_pkg::S_OFF: begin
          off_q <= addr_q - base;
          ge_q  <= (addr_q >= base);
        end
        bfa_pkg::S_SPAN: begin
          diff_q <= span_sub[63:0];
        end
        bfa_pkg::S_FIT: begin
          lo_q <= lo_calc;
          hi_q <= hi_calc;
        end
        bfa_pkg::S_FREE_WR: begin
          if (ram_rdata[lo_q[5:0]] && free_cnt < MAXV) begin
            free_cnt <= free_cnt + XW'(1);
          end
          res_ok <= 1'b1;
        end
        bfa_pkg::S_SCAN: begin
          if (rd_vld) begin
            if (cmd_q == bfa_pkg::CMD_ALLOC) begin
              if (any_free) begin
                start_q <= free_g;
                if (free_cnt != '0) free_cnt <= free_cnt - XW'(1);
              end
            end else if (cmd_q == bfa_pkg::CMD_RANGE) begin
              if (any_hit) begin
                start_q <= hit_start;
                lo_q    <= hit_start;
                hi_q    <= hit_start + cnt_q;
              end else begin
                run_q <= run_v[63];
              end
            end
          end
        end
        bfa_pkg::S_MARK: begin
          if (rd_vld && rd_last) begin
            free_cnt <= dec_cnt;
            if (cmd_q == bfa_pkg::CMD_FIXED) begin
              res_ok   <= 1'b1;
              res_addr <= addr_q;
            end
          end
        end
        bfa_pkg::S_ADDR: begin
          res_ok   <= 1'b1;
          res_addr <= base + (64'(start_q) << LOG2);
        end
        default: begin
          free_cnt <= free_cnt;
        end
      endcase
    end
  end

  assign busy                  = (state != bfa_pkg::S_IDLE);
  assign done                  = (state == bfa_pkg::S_DONE);
  assign result.ok             = res_ok;
  assign result.result_address = res_addr;
  assign result.free_frames    = free_cnt[12:0];

endmodule
